FILE: rtl/lpr_pkg.sv
// Shared types and constants for the LRU page frame replacer.
package lpr_pkg;

  // Result field widths as seen on the ports
  localparam int SLOT_OUT_W = 4;
  localparam int PAGE_OUT_W = 16;
  localparam int COUNT_W    = 32;

  // Configuration register file
  localparam int CFG_W      = 5;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_FRAMES_IN_USE   = '0;
  localparam logic [CFG_W-1:0]     FRAMES_IN_USE_RESET = CFG_W'(4);

  // Outcome of one lookup, already cut to the port widths
  typedef struct packed {
    logic                  was_hit;
    logic [SLOT_OUT_W-1:0] slot_used;
    logic                  evicted_valid;
    logic [PAGE_OUT_W-1:0] evicted_page;
  } lpr_lookup_t;

endpackage

FILE: rtl/lpr_frame_table.sv
// Frame table: page tags, valid bits, recency ranks, lookup and victim choice.
module lpr_frame_table
  import lpr_pkg::*;
#(
  parameter int FRAMES    = 16,
  parameter int PAGE_BITS = 16,
  localparam int SLOT_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1,
  localparam int CNT_W    = $clog2(FRAMES + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 clear,
  input  logic                 lookup_en,
  input  logic [PAGE_BITS-1:0] page,
  input  logic [CNT_W-1:0]     active,
  output lpr_lookup_t          look
);

  logic [PAGE_BITS-1:0] frame_page [FRAMES];
  logic [FRAMES-1:0]    frame_valid;
  logic [SLOT_W-1:0]    recency_rank [FRAMES];
  logic [SLOT_W-1:0]    rank_next [FRAMES];

  logic [FRAMES-1:0] in_use;
  logic [FRAMES-1:0] hit_vec;
  logic [FRAMES-1:0] free_vec;
  logic [FRAMES-1:0] old_vec;
  logic [SLOT_W-1:0] hit_idx;
  logic [SLOT_W-1:0] free_idx;
  logic [SLOT_W-1:0] old_idx;
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] oldest_rank;
  logic [CNT_W-1:0]  limit;
  logic              hit;
  logic              any_free;
  logic              evict;

  // Ranks of the valid frames always form 0..k-1, so a full set has
  // exactly one frame at rank active-1: the victim.
  assign oldest_rank = SLOT_W'(active - CNT_W'(1));

  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      in_use[i]   = CNT_W'(i) < active;
      hit_vec[i]  = in_use[i] & frame_valid[i] & (frame_page[i] == page);
      free_vec[i] = in_use[i] & ~frame_valid[i];
      old_vec[i]  = in_use[i] & frame_valid[i] & (recency_rank[i] == oldest_rank);
    end
  end

  // Lowest index wins in each encoder
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    old_idx  = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (hit_vec[i])  hit_idx  = SLOT_W'(i);
      if (free_vec[i]) free_idx = SLOT_W'(i);
      if (old_vec[i])  old_idx  = SLOT_W'(i);
    end
  end

  assign hit      = |hit_vec;
  assign any_free = |free_vec;
  assign evict    = ~hit & ~any_free;

  always_comb begin
    if (hit) begin
      slot  = hit_idx;
      limit = CNT_W'(recency_rank[hit_idx]);
    end else if (any_free) begin
      slot  = free_idx;
      limit = active;
    end else begin
      slot  = old_idx;
      limit = CNT_W'(oldest_rank);
    end
  end

  // Age every valid frame newer than the touched one; touched goes to rank 0
  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      if (SLOT_W'(i) == slot) begin
        rank_next[i] = '0;
      end else if (in_use[i] && frame_valid[i] && (CNT_W'(recency_rank[i]) < limit)) begin
        rank_next[i] = recency_rank[i] + SLOT_W'(1);
      end else begin
        rank_next[i] = recency_rank[i];
      end
    end
  end

  always_comb begin
    look.was_hit       = hit;
    look.slot_used     = SLOT_OUT_W'(slot);
    look.evicted_valid = evict;
    look.evicted_page  = evict ? PAGE_OUT_W'(frame_page[old_idx]) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      frame_valid <= '0;
      for (int i = 0; i < FRAMES; i++) begin
        recency_rank[i] <= '0;
      end
    end else if (lookup_en) begin
      for (int i = 0; i < FRAMES; i++) begin
        recency_rank[i] <= rank_next[i];
        if (!hit && (SLOT_W'(i) == slot)) begin
          frame_valid[i] <= 1'b1;
        end
      end
    end
  end

  // Tags are only read behind a valid bit
  always_ff @(posedge clk) begin
    if (lookup_en && !hit) begin
      for (int i = 0; i < FRAMES; i++) begin
        if (SLOT_W'(i) == slot) begin
          frame_page[i] <= page;
        end
      end
    end
  end

  a_single_hit : assert property (@(posedge clk) disable iff (rst)
    lookup_en |-> $onehot0(hit_vec))
    else $error("page resident in more than one frame");

  a_unique_victim : assert property (@(posedge clk) disable iff (rst)
    (lookup_en && !hit && !any_free) |-> $onehot(old_vec))
    else $error("full frame set without a single oldest frame");

  a_valid_kept : assert property (@(posedge clk) disable iff (rst)
    (lookup_en && !clear) |=> (($past(frame_valid) & ~frame_valid) == '0))
    else $error("frame emptied by a lookup");

endmodule

FILE: rtl/lru_page_frame_replacer.sv
// Top level of the LRU page frame replacer: command port, APB registers, totals.
//
// Usage:
//   Present a page on page_number and raise start; the word is taken at the
//   clock edge where start is high and busy is low. busy is high only while
//   rst is asserted, so a reference can be taken in every cycle.
//   Each reference yields one result word, shown for exactly one cycle with
//   done high: was_hit, slot_used, evicted_valid, evicted_page and the
//   saturating hit_total and fault_total after this reference.
//   A reference passes the input register, then the tag compare and rank
//   update over all frames on its way into the result register.
//   Throughput is one reference per cycle; the parallel compare and rank
//   update of the frame table over all frames make that possible.
//   The receiver cannot stall; it must take each word in its done cycle.
//   Reset empties all frames, clears the ranks and both totals and sets
//   frames_in_use to 4. A write to frames_in_use (APB, byte address 0) does
//   the same with the new frame count; write it only while no reference is
//   in flight. Values of 0 act as 1, values above FRAMES act as FRAMES.
module lru_page_frame_replacer
  import lpr_pkg::*;
#(
  parameter int FRAMES    = 16,
  parameter int PAGE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  // command channel
  input  logic                  start,
  output logic                  busy,
  input  logic [15:0]           page_number,
  // result channel
  output logic                  done,
  output logic                  was_hit,
  output logic [SLOT_OUT_W-1:0] slot_used,
  output logic                  evicted_valid,
  output logic [PAGE_OUT_W-1:0] evicted_page,
  output logic [COUNT_W-1:0]    hit_total,
  output logic [COUNT_W-1:0]    fault_total,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int CNT_W = $clog2(FRAMES + 1);

  logic [CFG_W-1:0]     frames_in_use;
  logic [CNT_W-1:0]     active;
  logic [REG_IDX_W-1:0] reg_index;
  logic                 cfg_wr;
  logic                 cfg_clear;
  logic                 accept;

  logic                 item_valid;
  logic [PAGE_BITS-1:0] item_page;
  lpr_lookup_t          look;

  logic [COUNT_W-1:0]   hit_count;
  logic [COUNT_W-1:0]   fault_count;

  // Nothing to hold off but reset itself
  assign busy   = rst;
  assign accept = start & ~busy;

  // Register file
  assign pready    = 1'b1;
  assign reg_index = paddr[APB_ADDR_W-1:2];
  assign cfg_wr    = psel & penable & pwrite & pready;
  assign cfg_clear = cfg_wr & (reg_index == REG_FRAMES_IN_USE);

  always_comb begin
    case (reg_index)
      REG_FRAMES_IN_USE: prdata = APB_DATA_W'(frames_in_use);
      default:           prdata = '0;
    endcase
  end

  // Clamp the programmed count to 1..FRAMES
  always_comb begin
    if (frames_in_use == '0) begin
      active = CNT_W'(1);
    end else if (int'(frames_in_use) > FRAMES) begin
      active = CNT_W'(FRAMES);
    end else begin
      active = CNT_W'(frames_in_use);
    end
  end

  lpr_frame_table #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_table (
    .clk       (clk),
    .rst       (rst),
    .clear     (cfg_clear),
    .lookup_en (item_valid),
    .page      (item_page),
    .active    (active),
    .look      (look)
  );

  // Totals are read straight from the counters; they load on the same edge
  // as the result register.
  assign hit_total   = hit_count;
  assign fault_total = fault_count;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= FRAMES_IN_USE_RESET;
      item_valid    <= 1'b0;
      done          <= 1'b0;
      hit_count     <= '0;
      fault_count   <= '0;
    end else begin
      item_valid <= accept;
      done       <= item_valid;
      if (cfg_clear) begin
        frames_in_use <= pwdata[CFG_W-1:0];
        hit_count     <= '0;
        fault_count   <= '0;
      end else if (item_valid) begin
        // hold at all ones once saturated
        if (look.was_hit) begin
          if (hit_count != '1) hit_count <= hit_count + COUNT_W'(1);
        end else begin
          if (fault_count != '1) fault_count <= fault_count + COUNT_W'(1);
        end
      end
    end
  end

  // Payload: input register and result register
  always_ff @(posedge clk) begin
    if (accept) begin
      item_page <= PAGE_BITS'(page_number);
    end
    if (item_valid) begin
      was_hit       <= look.was_hit;
      slot_used     <= look.slot_used;
      evicted_valid <= look.evicted_valid;
      evicted_page  <= look.evicted_page;
    end
  end

  a_done_follows : assert property (@(posedge clk) disable iff (rst)
    item_valid |=> done)
    else $error("reference without a result word");

  a_no_spurious : assert property (@(posedge clk) disable iff (rst)
    !item_valid |=> !done)
    else $error("result word without a reference");

  a_hit_no_evict : assert property (@(posedge clk) disable iff (rst)
    (done && was_hit) |-> !evicted_valid)
    else $error("hit reported with an eviction");

  a_evict_page_zero : assert property (@(posedge clk) disable iff (rst)
    (done && !evicted_valid) |-> (evicted_page == '0))
    else $error("evicted page set without an eviction");

endmodule

FILE: tb/lru_page_frame_replacer_test.sv
// Self-checking testbench for the LRU page frame replacer: page references against a frame model.
module lru_page_frame_replacer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lpr_pkg::*;

  localparam int FRAMES       = 16;
  localparam int PAGE_W       = 16;
  localparam int PHASE_ITEMS  = 140;   // ten random phases, about 1400 references in all
  localparam int DRAIN_CYCLES = 4;     // time for the result path to empty, plus margin
  localparam int STALL_LIMIT  = 2000;  // cycles with no handshake at all before giving up

  // Register index past the end of the map: writes to it must be dropped
  localparam logic [REG_IDX_W-1:0] REG_SPARE = REG_IDX_W'(1);

  // One result word as it appears on the ports
  typedef struct packed {
    lpr_lookup_t        lookup;
    logic [COUNT_W-1:0] hits;
    logic [COUNT_W-1:0] faults;
  } page_outcome_t;

  // Frame table model plus the queue of outcomes still owed by the block
  class page_table_scoreboard;
    logic [PAGE_W-1:0]  frame_page  [FRAMES];
    bit                 frame_valid [FRAMES];
    int                 frame_rank  [FRAMES];
    logic [CFG_W-1:0]   frames_cfg;
    logic [COUNT_W-1:0] hit_count;
    logic [COUNT_W-1:0] fault_count;
    page_outcome_t      outstanding [$];
    int unsigned        failures;

    function new();
      failures = 0;
      restart(FRAMES_IN_USE_RESET);
    endfunction

    // Empty every frame and clear the totals under a new frame count
    function void restart(logic [CFG_W-1:0] cfg);
      frames_cfg = cfg;
      for (int i = 0; i < FRAMES; i++) begin
        frame_page[i]  = '0;
        frame_valid[i] = 1'b0;
        frame_rank[i]  = 0;
      end
      hit_count   = '0;
      fault_count = '0;
    endfunction

    function int active_frames();
      int n;
      n = int'(frames_cfg);
      if (n == 0) n = 1;
      if (n > FRAMES) n = FRAMES;
      return n;
    endfunction

    // Look the page up, pick the frame, age the ranks and queue the outcome
    function void note_reference(logic [PAGE_W-1:0] page);
      page_outcome_t want;
      int n, slot, oldest, age_limit;
      bit hit, empty_found;
      n = active_frames();
      slot = 0;
      hit = 1'b0;
      empty_found = 1'b0;
      want = '0;
      for (int i = 0; i < n; i++) begin
        if (!hit && frame_valid[i] && frame_page[i] == page) begin
          slot = i;
          hit = 1'b1;
        end
      end
      if (!hit) begin
        for (int i = 0; i < n; i++) begin
          if (!empty_found && !frame_valid[i]) begin
            slot = i;
            empty_found = 1'b1;
          end
        end
        if (!empty_found) begin
          oldest = 0;
          for (int i = 1; i < n; i++) begin
            if (frame_rank[i] > frame_rank[oldest]) oldest = i;
          end
          slot = oldest;
          want.lookup.evicted_valid = 1'b1;
          want.lookup.evicted_page  = frame_page[oldest];
        end
      end
      // Only frames newer than the touched one grow older
      age_limit = frame_valid[slot] ? frame_rank[slot] : n;
      for (int i = 0; i < n; i++) begin
        if (i != slot && frame_valid[i] && frame_rank[i] < age_limit) frame_rank[i]++;
      end
      frame_rank[slot] = 0;
      if (hit) begin
        if (hit_count != '1) hit_count++;
      end else begin
        frame_page[slot]  = page;
        frame_valid[slot] = 1'b1;
        if (fault_count != '1) fault_count++;
      end
      want.lookup.was_hit   = hit;
      want.lookup.slot_used = SLOT_OUT_W'(slot);
      want.hits             = hit_count;
      want.faults           = fault_count;
      outstanding.push_back(want);
    endfunction

    function void compare_field(string name, logic [COUNT_W-1:0] want, logic [COUNT_W-1:0] got);
      if (got !== want) begin
        failures++;
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      end
    endfunction

    function void check_result(page_outcome_t got);
      page_outcome_t want;
      if (outstanding.size() == 0) begin
        failures++;
        $error("result word with no reference outstanding, slot_used %0d",
               got.lookup.slot_used);
        return;
      end
      want = outstanding.pop_front();
      compare_field("was_hit", COUNT_W'(want.lookup.was_hit),
                    COUNT_W'(got.lookup.was_hit));
      compare_field("slot_used", COUNT_W'(want.lookup.slot_used),
                    COUNT_W'(got.lookup.slot_used));
      compare_field("evicted_valid", COUNT_W'(want.lookup.evicted_valid),
                    COUNT_W'(got.lookup.evicted_valid));
      compare_field("evicted_page", COUNT_W'(want.lookup.evicted_page),
                    COUNT_W'(got.lookup.evicted_page));
      compare_field("hit_total", want.hits, got.hits);
      compare_field("fault_total", want.faults, got.faults);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic [15:0]           page_number;
  logic                  done;
  logic                  was_hit;
  logic [SLOT_OUT_W-1:0] slot_used;
  logic                  evicted_valid;
  logic [PAGE_OUT_W-1:0] evicted_page;
  logic [COUNT_W-1:0]    hit_total;
  logic [COUNT_W-1:0]    fault_total;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  page_table_scoreboard sb = new();
  int unsigned quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lru_page_frame_replacer i_dut (.*);

  // Sample both channels at the rising edge; inputs only move on the falling edge
  always @(posedge clk) begin : watch_ports
    page_outcome_t got;
    if (!rst) begin
      if (start && !busy) sb.note_reference(page_number);
      if (done) begin
        got.lookup.was_hit       = was_hit;
        got.lookup.slot_used     = slot_used;
        got.lookup.evicted_valid = evicted_valid;
        got.lookup.evicted_page  = evicted_page;
        got.hits                 = hit_total;
        got.faults               = fault_total;
        sb.check_result(got);
      end
    end
  end

  // Give up when no word, result or register access has moved for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("lru_page_frame_replacer: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one page and hold it until the block takes the word
  task automatic issue_page(logic [PAGE_W-1:0] page);
    @(negedge clk);
    start       <= 1'b1;
    page_number <= page;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drop start for a number of cycles; scramble the page lines meanwhile
  task automatic hold_off(int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk);
      start       <= 1'b0;
      page_number <= PAGE_W'($urandom());
    end
  endtask

  // Stop issuing, wait for every owed result, then let the pipeline empty
  task automatic settle();
    hold_off(1);
    while (sb.outstanding.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One APB transfer: setup cycle, then access until pready
  task automatic apb_access(logic [REG_IDX_W-1:0] idx, bit write_en,
                            logic [APB_DATA_W-1:0] data, output logic [APB_DATA_W-1:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write_en;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_readback();
    logic [APB_DATA_W-1:0] value;
    apb_access(REG_FRAMES_IN_USE, 1'b0, '0, value);
    if (value !== APB_DATA_W'(sb.frames_cfg)) begin
      sb.failures++;
      $error("frames_in_use: expected 0x%0h, got 0x%0h", sb.frames_cfg, value);
    end
  endtask

  // Write a register with the block idle; a frame count write restarts the model too
  task automatic configure(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] data);
    logic [APB_DATA_W-1:0] unused;
    settle();
    apb_access(idx, 1'b1, data, unused);
    if (idx == REG_FRAMES_IN_USE) sb.restart(data[CFG_W-1:0]);
    check_readback();
  endtask

  // Random references under the current frame count: mostly a small working set
  // so that hits and evictions dominate, with stray pages and the all-zero and
  // all-one pages mixed in; the sender works in bursts with gaps between them
  task automatic run_phase(int unsigned items);
    logic [PAGE_W-1:0] pool [$];
    logic [PAGE_W-1:0] page;
    int unsigned burst, r;
    pool.delete();
    repeat (sb.active_frames() + $urandom_range(0, 4)) pool.push_back(PAGE_W'($urandom()));
    burst = 0;
    repeat (items) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        // a third of the bursts follow on with no gap at all
        if ($urandom_range(0, 2) != 0) hold_off($urandom_range(1, 6));
      end
      burst--;
      r = $urandom_range(0, 99);
      if (r < 72) page = pool[$urandom_range(0, pool.size() - 1)];
      else if (r < 90) page = PAGE_W'($urandom());
      else if (r < 95) page = '0;
      else page = '1;
      // drift the working set now and then so old pages age out
      if (r < 3) pool[$urandom_range(0, pool.size() - 1)] = PAGE_W'($urandom());
      issue_page(page);
    end
  endtask

  initial begin : stimulus
    rst         = 1'b1;
    start       = 1'b0;
    page_number = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    check_readback();

    // Four frames out of reset: fill, hit, then evict the least recent in turn
    issue_page(16'h0000);
    issue_page(16'hFFFF);
    issue_page(16'h0000);
    issue_page(16'h8001);
    issue_page(16'h7FFE);
    issue_page(16'h0000);
    issue_page(16'h1234);
    issue_page(16'hFFFF);
    issue_page(16'h7FFE);
    issue_page(16'h0000);
    issue_page(16'h1234);
    issue_page(16'h5555);

    // Write to an unmapped register: frames and totals must survive it
    configure(REG_SPARE, 32'hFFFF_FFFF);
    issue_page(16'h0000);
    issue_page(16'h5555);
    issue_page(16'hAAAA);

    // Frame count of zero behaves as a single frame
    configure(REG_FRAMES_IN_USE, 32'd0);
    issue_page(16'hAAAA);
    issue_page(16'hAAAA);
    issue_page(16'h5555);
    issue_page(16'hFFFF);
    issue_page(16'hFFFF);

    // Random phases across the frame counts, extremes and out-of-range values included
    configure(REG_FRAMES_IN_USE, 32'd16);
    run_phase(PHASE_ITEMS);
    configure(REG_FRAMES_IN_USE, 32'd1);
    run_phase(PHASE_ITEMS);
    configure(REG_FRAMES_IN_USE, 32'd17);
    run_phase(PHASE_ITEMS);
    configure(REG_FRAMES_IN_USE, 32'd2);
    run_phase(PHASE_ITEMS);
    configure(REG_FRAMES_IN_USE, {27'($urandom_range(0, 32'h07FF_FFFF)), 5'd31});
    run_phase(PHASE_ITEMS);
    configure(REG_FRAMES_IN_USE, 32'd8);
    run_phase(PHASE_ITEMS);
    configure(REG_FRAMES_IN_USE, $urandom_range(0, 31));
    run_phase(PHASE_ITEMS);
    configure(REG_FRAMES_IN_USE, $urandom());
    run_phase(PHASE_ITEMS);
    configure(REG_FRAMES_IN_USE, 32'd3);
    run_phase(PHASE_ITEMS);
    configure(REG_FRAMES_IN_USE, 32'd4);
    run_phase(PHASE_ITEMS);

    settle();
    if (sb.failures == 0 && sb.outstanding.size() == 0) begin
      $display("lru_page_frame_replacer: match");
    end else begin
      $display("lru_page_frame_replacer: mismatch");
    end
    $finish;
  end
endmodule
